// ----- sv/sarp_pkg.sv -----
// Shared types, constants and helpers for the servo angle ramp block.
package sarp_pkg;

  localparam int NUM_CHANNELS = 4;
  localparam int CH_W = 2;
  localparam int ANGLE_W = 8;
  localparam int STEP_W = 10;
  localparam int CMP_W = 12;
  localparam int STATUS_W = 2;

  localparam logic [ANGLE_W-1:0] ANGLE_MAX = 8'd180;
  localparam logic [ANGLE_W-1:0] HOME_ANGLE = 8'd60;
  localparam logic [STEP_W-1:0] STEP_TICKS_RESET = 10'd30;

  // 2000/180 = 100/9; x/9 is taken as (x*7282)>>16, exact for x below 18000.
  localparam int CMP_OFFSET = 499;
  localparam logic [19:0] CMP_RECIP = 20'd728200;
  localparam int CMP_SHIFT = 16;

  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_SET = 1'b1;

  localparam logic [STATUS_W-1:0] ST_STARTED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_STEPPED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_AT_TARGET = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BUSY = 2'd3;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_STEP_TICKS = 1'b0;

  typedef struct packed {
    logic            latch_item;
    logic            do_set;
    logic            do_step;
    logic [CH_W-1:0] sel;
  } sarp_cmd_t;

  typedef struct packed {
    logic [NUM_CHANNELS-1:0] step_mask;
    logic                    out_free;
  } sarp_stat_t;

  function automatic logic [CMP_W-1:0] compare_for(input logic [ANGLE_W-1:0] angle);
    logic [27:0] prod;
    prod = 28'(angle) * 28'(CMP_RECIP);
    return CMP_W'(CMP_OFFSET) + CMP_W'(prod[27:CMP_SHIFT]);
  endfunction

endpackage

// ----- sv/sarp_in_if.sv -----
// Input channel interface: command beats with valid/ready handshake.
interface sarp_in_if;
  logic                             valid;
  logic                             ready;
  logic                             func;
  logic [sarp_pkg::CH_W-1:0]        channel;
  logic [sarp_pkg::ANGLE_W-1:0]     target_angle;

  modport source (output valid, func, channel, target_angle, input ready);
  modport sink (input valid, func, channel, target_angle, output ready);
endinterface

// ----- sv/sarp_out_if.sv -----
// Output channel interface: result beats with valid/ready handshake.
interface sarp_out_if;
  logic                              valid;
  logic                              ready;
  logic [sarp_pkg::CH_W-1:0]         out_channel;
  logic [sarp_pkg::CMP_W-1:0]        compare_value;
  logic [sarp_pkg::ANGLE_W-1:0]      position;
  logic [sarp_pkg::STATUS_W-1:0]     status;
  logic                              last;

  modport source (output valid, out_channel, compare_value, position, status, last,
                  input ready);
  modport sink (input valid, out_channel, compare_value, position, status, last,
                output ready);
endinterface

// ----- sv/sarp_ctrl.sv -----
// Controller state machine: accepts commands and sequences the channel scan.
module sarp_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cmd_valid,
  output logic                 cmd_ready,
  input  logic                 cmd_func,
  input  sarp_pkg::sarp_stat_t stat,
  output sarp_pkg::sarp_cmd_t  ctl
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SET  = 3'b010,
    S_TICK = 3'b100
  } state_t;

  state_t                    state, state_next;
  logic [sarp_pkg::CH_W-1:0] idx, idx_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

  always_comb begin
    state_next     = state;
    idx_next       = idx;
    cmd_ready      = 1'b0;
    ctl.latch_item = 1'b0;
    ctl.do_set     = 1'b0;
    ctl.do_step    = 1'b0;
    ctl.sel        = idx;
    case (state)
      S_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          ctl.latch_item = 1'b1;
          idx_next       = '0;
          state_next     = (cmd_func == sarp_pkg::FUNC_SET) ? S_SET : S_TICK;
        end
      end
      S_SET: begin
        if (stat.out_free) begin
          ctl.do_set = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_TICK: begin
        if (!stat.step_mask[idx] || stat.out_free) begin
          ctl.do_step = stat.step_mask[idx];
          if (idx == sarp_pkg::CH_W'(sarp_pkg::NUM_CHANNELS - 1)) begin
            state_next = S_IDLE;
          end else begin
            idx_next = idx + 1'b1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- sv/sarp_dp.sv -----
// Datapath: channel state, step register, item latch and output register.
module sarp_dp (
  input  logic                             clk,
  input  logic                             rst,
  input  sarp_pkg::sarp_cmd_t              ctl,
  output sarp_pkg::sarp_stat_t             stat,
  input  logic                             cmd_func,
  input  logic [sarp_pkg::CH_W-1:0]        cmd_channel,
  input  logic [sarp_pkg::ANGLE_W-1:0]     cmd_target_angle,
  input  logic                             cfg_we,
  input  logic [sarp_pkg::STEP_W-1:0]      cfg_step_ticks,
  output logic [sarp_pkg::STEP_W-1:0]      step_ticks,
  output logic                             res_valid,
  input  logic                             res_ready,
  output logic [sarp_pkg::CH_W-1:0]        res_channel,
  output logic [sarp_pkg::CMP_W-1:0]       res_compare,
  output logic [sarp_pkg::ANGLE_W-1:0]     res_position,
  output logic [sarp_pkg::STATUS_W-1:0]    res_status,
  output logic                             res_last
);

  localparam int N = sarp_pkg::NUM_CHANNELS;

  logic [sarp_pkg::ANGLE_W-1:0] cur [N];
  logic [sarp_pkg::ANGLE_W-1:0] goal [N];
  logic [sarp_pkg::STEP_W-1:0]  cnt [N];
  logic [N-1:0]                 step_mask;

  logic [sarp_pkg::CH_W-1:0]    item_channel;
  logic [sarp_pkg::ANGLE_W-1:0] item_target;

  logic [sarp_pkg::STEP_W-1:0]  limit;
  logic [N-1:0]                 moving;
  logic [N-1:0]                 will_step;
  logic [sarp_pkg::STEP_W-1:0]  cnt_inc [N];
  logic [sarp_pkg::ANGLE_W-1:0] tgt_clamped;
  logic [sarp_pkg::ANGLE_W-1:0] sel_cur;
  logic [sarp_pkg::ANGLE_W-1:0] sel_goal;
  logic [sarp_pkg::ANGLE_W-1:0] stepped_angle;
  logic [sarp_pkg::STATUS_W-1:0] set_status;
  logic                         later_steps;
  logic [sarp_pkg::CH_W-1:0]    addr;
  logic                         load;

  assign limit = (step_ticks == '0) ? sarp_pkg::STEP_W'(1) : step_ticks;

  always_comb begin
    for (int i = 0; i < N; i++) begin
      moving[i]    = cur[i] != goal[i];
      cnt_inc[i]   = cnt[i] + 1'b1;
      will_step[i] = moving[i] && (cnt_inc[i] >= limit);
    end
  end

  assign addr     = ctl.do_set ? item_channel : ctl.sel;
  assign sel_cur  = cur[addr];
  assign sel_goal = goal[addr];

  assign tgt_clamped = (item_target > sarp_pkg::ANGLE_MAX) ? sarp_pkg::ANGLE_MAX : item_target;

  always_comb begin
    if (sel_cur != sel_goal) begin
      set_status = sarp_pkg::ST_BUSY;
    end else if (tgt_clamped == sel_cur) begin
      set_status = sarp_pkg::ST_AT_TARGET;
    end else begin
      set_status = sarp_pkg::ST_STARTED;
    end
  end

  always_comb begin
    if (sel_cur < sel_goal) begin
      stepped_angle = sel_cur + 1'b1;
    end else if (sel_cur != '0) begin
      stepped_angle = sel_cur - 1'b1;
    end else begin
      stepped_angle = sel_cur;
    end
  end

  always_comb begin
    later_steps = 1'b0;
    for (int j = 0; j < N; j++) begin
      if (sarp_pkg::CH_W'(j) > ctl.sel) begin
        later_steps = later_steps | step_mask[j];
      end
    end
  end

  assign load = ctl.do_set || ctl.do_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_ticks <= sarp_pkg::STEP_TICKS_RESET;
    end else if (cfg_we) begin
      step_ticks <= cfg_step_ticks;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < N; i++) begin
        cur[i]  <= sarp_pkg::HOME_ANGLE;
        goal[i] <= sarp_pkg::HOME_ANGLE;
        cnt[i]  <= '0;
      end
      step_mask <= '0;
    end else begin
      if (ctl.latch_item && cmd_func == sarp_pkg::FUNC_TICK) begin
        step_mask <= will_step;
        for (int i = 0; i < N; i++) begin
          if (will_step[i]) begin
            cnt[i] <= '0;
          end else if (moving[i]) begin
            cnt[i] <= cnt_inc[i];
          end
        end
      end
      if (ctl.do_set && set_status == sarp_pkg::ST_STARTED) begin
        goal[addr] <= tgt_clamped;
        cnt[addr]  <= '0;
      end
      if (ctl.do_step) begin
        cur[addr] <= stepped_angle;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.latch_item) begin
      item_channel <= cmd_channel;
      item_target  <= cmd_target_angle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_channel <= addr;
      if (ctl.do_set) begin
        res_position <= sel_cur;
        res_compare  <= sarp_pkg::compare_for(sel_cur);
        res_status   <= set_status;
        res_last     <= 1'b1;
      end else begin
        res_position <= stepped_angle;
        res_compare  <= sarp_pkg::compare_for(stepped_angle);
        res_status   <= sarp_pkg::ST_STEPPED;
        res_last     <= !later_steps;
      end
    end
  end

  assign stat.step_mask = step_mask;
  assign stat.out_free  = !res_valid || res_ready;

endmodule

// ----- sv/servo_angle_ramp_pwm.sv -----
// Top level of the four-channel servo angle ramp with PWM compare output.
//
// Commands arrive as beats on cmd. A set-target beat (func = 1) clamps the
// angle to 180 and yields exactly one result beat on res: ramp started,
// already at target, or refused because the channel is still moving.
// A tick beat (func = 0) advances every moving channel's tick counter and
// yields one result beat for each channel that steps one degree, from
// channel 0 upward; it may yield none. The last result of a command has
// last set. Each result carries 499 + position*2000/180 as compare_value.
// A set-target beat occupies the block through the SET state and a tick beat
// through the TICK scan, which visits the channels in turn by the scan counter;
// cmd.ready is high only while the controller is idle.
// The result of a set-target beat is loaded into the result register in SET,
// and the result for the step of channel k when the scan reaches channel k.
// The result register lets the next command be taken while a result is
// still waiting; while a result waits and res.ready is low the scan holds
// at a stepping channel until its result can be loaded, so no beat is dropped.
// Reset puts every channel at 60 degrees, idle, with step_ticks at 30.
// step_ticks is written over the APB port at address 0; zero acts as one.
module servo_angle_ramp_pwm (
  input  logic                               clk,
  input  logic                               rst,
  sarp_in_if.sink                            cmd,
  sarp_out_if.source                         res,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [sarp_pkg::PADDR_W-1:0]       paddr,
  input  logic [sarp_pkg::PDATA_W-1:0]       pwdata,
  output logic [sarp_pkg::PDATA_W-1:0]       prdata,
  output logic                               pready
);

  sarp_pkg::sarp_cmd_t               ctl;
  sarp_pkg::sarp_stat_t              stat;
  logic                              cfg_we;
  logic [sarp_pkg::STEP_W-1:0]       step_ticks;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == sarp_pkg::REG_STEP_TICKS);
  assign prdata = (paddr[2] == sarp_pkg::REG_STEP_TICKS) ?
                  sarp_pkg::PDATA_W'(step_ticks) : '0;

  sarp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd.valid),
    .cmd_ready (cmd.ready),
    .cmd_func  (cmd.func),
    .stat      (stat),
    .ctl       (ctl)
  );

  sarp_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .ctl              (ctl),
    .stat             (stat),
    .cmd_func         (cmd.func),
    .cmd_channel      (cmd.channel),
    .cmd_target_angle (cmd.target_angle),
    .cfg_we           (cfg_we),
    .cfg_step_ticks   (pwdata[sarp_pkg::STEP_W-1:0]),
    .step_ticks       (step_ticks),
    .res_valid        (res.valid),
    .res_ready        (res.ready),
    .res_channel      (res.out_channel),
    .res_compare      (res.compare_value),
    .res_position     (res.position),
    .res_status       (res.status),
    .res_last         (res.last)
  );

endmodule

// ----- tb/ramp_tracker_pkg.sv -----
// Scoreboard class that predicts and checks the servo angle ramp results.
`timescale 1ns / 1ps

package ramp_tracker_pkg;
  import sarp_pkg::*;

  typedef struct packed {
    logic [CH_W-1:0]     chan;
    logic [CMP_W-1:0]    cmp;
    logic [ANGLE_W-1:0]  pos;
    logic [STATUS_W-1:0] stat;
    logic                last;
  } servo_result_t;

  class ramp_tracker;
    logic [ANGLE_W-1:0] angle_now [NUM_CHANNELS];
    logic [ANGLE_W-1:0] angle_goal[NUM_CHANNELS];
    logic [STEP_W-1:0]  tick_cnt  [NUM_CHANNELS];
    logic [STEP_W-1:0]  step_ticks;
    servo_result_t      expected_pulses[$];
    int                 mismatches;
    int                 commands;
    int                 results;
    int                 status_hits[4];
    int                 floor_hits;

    function new();
      step_ticks = STEP_TICKS_RESET;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        angle_now[c] = HOME_ANGLE;
        angle_goal[c] = HOME_ANGLE;
        tick_cnt[c] = '0;
      end
    endfunction

    function logic [CMP_W-1:0] pulse_width(logic [ANGLE_W-1:0] a);
      return CMP_W'(499 + (int'(a) * 2000) / 180);
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) $display("tb: MISMATCH %s", msg);
    endfunction

    function int pending();
      return expected_pulses.size();
    endfunction

    function void set_step_ticks(logic [STEP_W-1:0] val);
      step_ticks = val;
    endfunction

    function void check_readback(logic [STEP_W-1:0] got);
      if (got !== step_ticks)
        flag($sformatf("step_ticks readback: expected %0d, got %0d", step_ticks, got));
    endfunction

    function void queue_pulse(int c, logic [STATUS_W-1:0] st);
      servo_result_t r;
      r.chan = CH_W'(c);
      r.pos = angle_now[c];
      r.cmp = pulse_width(angle_now[c]);
      r.stat = st;
      r.last = 1'b0;
      expected_pulses.push_back(r);
    endfunction

    function void note_command(logic f, logic [CH_W-1:0] ch, logic [ANGLE_W-1:0] ang);
      logic [ANGLE_W-1:0] want;
      int first;
      int limit;
      servo_result_t r;
      commands++;
      first = expected_pulses.size();
      if (f == FUNC_SET) begin
        want = (ang > ANGLE_MAX) ? ANGLE_MAX : ang;
        if (angle_now[ch] != angle_goal[ch]) begin
          queue_pulse(ch, ST_BUSY);
        end else if (want == angle_now[ch]) begin
          queue_pulse(ch, ST_AT_TARGET);
        end else begin
          angle_goal[ch] = want;
          tick_cnt[ch] = '0;
          queue_pulse(ch, ST_STARTED);
        end
      end else begin
        limit = (step_ticks == 0) ? 1 : int'(step_ticks);
        for (int c = 0; c < NUM_CHANNELS; c++) begin
          if (angle_now[c] != angle_goal[c]) begin
            tick_cnt[c] = tick_cnt[c] + 1'b1;
            if (int'(tick_cnt[c]) >= limit) begin
              tick_cnt[c] = '0;
              if (angle_now[c] < angle_goal[c]) angle_now[c] = angle_now[c] + 1'b1;
              else if (angle_now[c] > 0) angle_now[c] = angle_now[c] - 1'b1;
              queue_pulse(c, ST_STEPPED);
            end
          end
        end
      end
      if (expected_pulses.size() > first) begin
        r = expected_pulses.pop_back();
        r.last = 1'b1;
        expected_pulses.push_back(r);
      end
    endfunction

    function void check_result(servo_result_t got);
      servo_result_t want;
      results++;
      if (expected_pulses.size() == 0) begin
        flag($sformatf("unexpected result: ch %0d cmp %0d pos %0d status %0d last %0b",
                       got.chan, got.cmp, got.pos, got.stat, got.last));
        return;
      end
      want = expected_pulses.pop_front();
      status_hits[want.stat]++;
      if (want.stat == ST_STEPPED && want.pos == 0) floor_hits++;
      if (got.chan !== want.chan || got.cmp !== want.cmp || got.pos !== want.pos ||
          got.stat !== want.stat || got.last !== want.last)
        flag($sformatf({"result %0d: expected ch %0d cmp %0d pos %0d status %0d last %0b,",
                        " got ch %0d cmp %0d pos %0d status %0d last %0b"},
                       results, want.chan, want.cmp, want.pos, want.stat, want.last,
                       got.chan, got.cmp, got.pos, got.stat, got.last));
    endfunction
  endclass

endpackage

// ----- tb/servo_angle_ramp_pwm_tb.sv -----
// Top-level testbench for the servo angle ramp block with PWM compare output.
`timescale 1ns / 1ps

module servo_angle_ramp_pwm_tb;
  import sarp_pkg::*;
  import ramp_tracker_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int LONG_HOLD = 300;
  localparam int SETTLE_CYCLES = 12;
  localparam logic [PADDR_W-1:0] STEP_TICKS_ADDR = PADDR_W'(4 * int'(REG_STEP_TICKS));

  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  sarp_in_if  cmd_if ();
  sarp_out_if res_if ();

  servo_angle_ramp_pwm uut (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd_if),
    .res     (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  ramp_tracker tracker;
  int          src_idle_pct;
  int          sink_idle_pct;
  bit          sink_quiet;
  bit          hold_request;
  int          idle_cycles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else if (sink_quiet) begin
        res_if.ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        res_if.ready <= 1'b0;
      end else if ($urandom_range(0, 99) < sink_idle_pct) begin
        stall_left = $urandom_range(0, 10);
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && res_if.valid && res_if.ready)
      tracker.check_result(servo_result_t'{chan: res_if.out_channel,
                                           cmp: res_if.compare_value,
                                           pos: res_if.position,
                                           stat: res_if.status,
                                           last: res_if.last});
  end

  always @(posedge clk) begin
    if (rst || (cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb: timeout, %0d results still outstanding", tracker.pending());
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send_command(input logic f, input logic [CH_W-1:0] ch,
                              input logic [ANGLE_W-1:0] ang);
    cmd_if.valid <= 1'b1;
    cmd_if.func <= f;
    cmd_if.channel <= ch;
    cmd_if.target_angle <= ang;
    do @(posedge clk); while (!cmd_if.ready);
    tracker.note_command(f, ch, ang);
  endtask

  task automatic source_gap();
    if ($urandom_range(0, 99) < src_idle_pct) begin
      cmd_if.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  task automatic paced_command(input logic f, input logic [CH_W-1:0] ch,
                               input logic [ANGLE_W-1:0] ang);
    source_gap();
    send_command(f, ch, ang);
  endtask

  task automatic wait_for_results();
    cmd_if.valid <= 1'b0;
    while (tracker.pending() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_step_ticks(input logic [STEP_W-1:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= STEP_TICKS_ADDR;
    pwdata <= PDATA_W'(val);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    tracker.set_step_ticks(val);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    tracker.check_readback(prdata[STEP_W-1:0]);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Mostly ticks to keep ramps moving; targets lean toward 0, the clamp range
  // and the present angle.
  task automatic send_random(input int count, input int set_pct, input int hold_at,
                             input int pause_at);
    int                 burst_left;
    int                 pick;
    logic [CH_W-1:0]    ch;
    logic [ANGLE_W-1:0] ang;
    burst_left = 0;
    for (int i = 0; i < count; i++) begin
      if (i == hold_at) begin
        hold_request = 1'b1;
        burst_left = 16;
      end
      if (i == pause_at) wait_for_results();
      if (burst_left > 0) burst_left--;
      else source_gap();
      ch = CH_W'($urandom_range(0, NUM_CHANNELS - 1));
      if ($urandom_range(0, 99) < set_pct) begin
        pick = $urandom_range(0, 9);
        if (pick < 2) ang = '0;
        else if (pick == 2) ang = ANGLE_W'($urandom_range(180, 255));
        else if (pick == 3) ang = tracker.angle_now[ch];
        else ang = ANGLE_W'($urandom_range(0, 255));
        send_command(FUNC_SET, ch, ang);
      end else begin
        send_command(FUNC_TICK, ch, ANGLE_W'($urandom));
      end
    end
  endtask

  initial begin
    tracker = new();
    cmd_if.valid <= 1'b0;
    cmd_if.func <= FUNC_TICK;
    cmd_if.channel <= '0;
    cmd_if.target_angle <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    rst <= 1'b1;
    src_idle_pct = 0;
    sink_idle_pct = 0;
    sink_quiet = 1'b0;
    hold_request = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset values: every channel at 60, step_ticks at 30.
    src_idle_pct = 25;
    sink_idle_pct = 25;
    paced_command(FUNC_SET, 2'd0, HOME_ANGLE);
    paced_command(FUNC_SET, 2'd1, 8'd255);
    paced_command(FUNC_SET, 2'd1, 8'd10);
    paced_command(FUNC_SET, 2'd2, 8'd0);
    paced_command(FUNC_SET, 2'd3, 8'd61);
    paced_command(FUNC_SET, 2'd0, ANGLE_MAX);
    paced_command(FUNC_TICK, 2'd3, 8'hFF);
    paced_command(FUNC_TICK, 2'd0, 8'h00);
    paced_command(FUNC_TICK, 2'd2, 8'hA5);
    wait_for_results();

    // A zero step count behaves as one: every tick steps each moving channel.
    write_step_ticks('0);
    paced_command(FUNC_TICK, 2'd1, 8'h5A);
    paced_command(FUNC_TICK, 2'd2, 8'hC3);
    paced_command(FUNC_SET, 2'd3, 8'd61);
    paced_command(FUNC_SET, 2'd3, 8'd60);
    paced_command(FUNC_SET, 2'd0, 8'd0);
    paced_command(FUNC_SET, 2'd1, 8'd255);
    paced_command(FUNC_TICK, 2'd0, 8'h3C);
    paced_command(FUNC_TICK, 2'd3, 8'h81);
    wait_for_results();

    write_step_ticks(10'd1);
    src_idle_pct = 30;
    sink_idle_pct = 30;
    send_random(80, 30, 35, 65);
    wait_for_results();

    write_step_ticks(10'd3);
    src_idle_pct = 0;
    sink_idle_pct = 40;
    send_random(50, 30, -1, -1);
    wait_for_results();

    // Largest step count: a handful of ticks leaves the new ramps short of a step.
    write_step_ticks(10'd1023);
    sink_idle_pct = 10;
    send_command(FUNC_SET, 2'd0, (tracker.angle_now[0] < 8'd90) ? ANGLE_MAX : 8'd0);
    send_command(FUNC_SET, 2'd2, (tracker.angle_now[2] < 8'd90) ? ANGLE_MAX : 8'd0);
    repeat (20) send_command(FUNC_TICK, CH_W'($urandom), ANGLE_W'($urandom));
    wait_for_results();

    write_step_ticks(10'd2);
    sink_quiet = 1'b1;
    send_random(55, 35, -1, -1);
    wait_for_results();
    repeat (20) @(posedge clk);

    $display("tb: %0d commands, %0d results: %0d started, %0d stepped, %0d at target, %0d refused",
             tracker.commands, tracker.results, tracker.status_hits[ST_STARTED],
             tracker.status_hits[ST_STEPPED], tracker.status_hits[ST_AT_TARGET],
             tracker.status_hits[ST_BUSY]);
    $display("tb: step_ticks 30, 0, 1, 3, 1023, 2 exercised; %0d steps ended at 0 degrees",
             tracker.floor_hits);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: %0d mismatches, %0d results missing", tracker.mismatches,
               tracker.pending());
      $display("tb: failure");
    end
    $finish;
  end

endmodule
